// ----- design/gradient_nonmax_suppression_top_assert.svh -----
// Assertion macros for the non-maximum suppression block.
`ifndef GRADIENT_NONMAX_SUPPRESSION_TOP_ASSERT_SVH
`define GRADIENT_NONMAX_SUPPRESSION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define GNMS_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define GNMS_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/gnms_pkg.sv -----
package gnms_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int MAG_BITS  = 9;
	localparam int GRAD_BITS = 9;
	localparam int ADDR_BITS = $clog2(MAX_WIDTH);
	localparam int ROW_BITS  = 12;
	localparam int COL_BITS  = 11;
	localparam int CFG_BITS  = 12;
	localparam int PROD_BITS = MAG_BITS + GRAD_BITS;

	localparam logic [CFG_BITS-1:0] DEFAULT_WIDTH  = CFG_BITS'(640);
	localparam logic [CFG_BITS-1:0] DEFAULT_HEIGHT = CFG_BITS'(480);
	localparam logic [CFG_BITS-1:0] MIN_DIM        = CFG_BITS'(3);

	// Bit positions of the result mask carried with each beat.
	localparam int RES_CENTER   = 0;
	localparam int RES_ROW_END  = 1;
	localparam int RES_LAST_ROW = 2;
	localparam int RES_CORNER   = 3;
	localparam int RES_COUNT    = 4;

	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [MAG_BITS-1:0]         mag_t;
	typedef logic signed [GRAD_BITS-1:0] grad_t;
	typedef logic [GRAD_BITS-1:0]        abs_t;
	typedef logic [PROD_BITS-1:0]        prod_t;

	typedef struct packed {
		mag_t  upper;
		mag_t  middle;
		grad_t gy;
		grad_t gx;
	} line_entry_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]  row;
		logic [ROW_BITS-1:0]  row_m1;
		logic [COL_BITS-1:0]  col;
		logic [COL_BITS-1:0]  col_m1;
		logic [RES_COUNT-1:0] mask;
		logic                 border;
	} tag_t;

	typedef struct packed {
		logic force0;
		mag_t m;
		abs_t major;
		abs_t minor;
		mag_t g1;
		mag_t g2;
		mag_t g3;
		mag_t g4;
	} sel_t;

	typedef struct packed {
		logic  force0;
		prod_t pm;
		prod_t p1;
		prod_t p2;
		prod_t p3;
		prod_t p4;
	} prods_t;

endpackage

// ----- design/gnms_line_buf.sv -----
module gnms_line_buf (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [gnms_pkg::ADDR_BITS-1:0] rd_addr,
	output gnms_pkg::line_entry_t          rd_data,
	input  logic                           wr_en,
	input  logic [gnms_pkg::ADDR_BITS-1:0] wr_addr,
	input  gnms_pkg::line_entry_t          wr_data
);
	import gnms_pkg::*;

	line_entry_t mem [MAX_WIDTH];
	line_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/gnms_window.sv -----
module gnms_window (
	input  logic                  clk,
	input  logic                  en,
	input  gnms_pkg::line_entry_t line,
	input  gnms_pkg::mag_t        mag,
	input  logic                  border,
	output gnms_pkg::sel_t        sel_s2
);
	import gnms_pkg::*;

	mag_t  win1_q [3];
	mag_t  win2_q [3];
	grad_t held_gx_q;
	grad_t held_gy_q;
	sel_t  sel_q;
	sel_t  sel_d;

	function automatic abs_t mag_of(grad_t x);
		abs_t u;
		u = abs_t'(x);
		return u[GRAD_BITS-1] ? (~u + abs_t'(1)) : u;
	endfunction

	always_comb begin
		abs_t ax;
		abs_t ay;
		logic same;
		logic gx_pos;
		logic gy_pos;
		ax = mag_of(held_gx_q);
		ay = mag_of(held_gy_q);
		gx_pos = !held_gx_q[GRAD_BITS-1] && (held_gx_q != '0);
		gy_pos = !held_gy_q[GRAD_BITS-1] && (held_gy_q != '0);
		same = (gx_pos && gy_pos) || (held_gx_q[GRAD_BITS-1] && held_gy_q[GRAD_BITS-1]);
		sel_d.m = win2_q[1];
		sel_d.force0 = border || (win2_q[1] == '0) ||
			((held_gx_q == '0) && (held_gy_q == '0));
		if (ay > ax) begin
			sel_d.major = ay;
			sel_d.minor = ax;
			sel_d.g2 = win2_q[0];
			sel_d.g4 = win2_q[2];
			sel_d.g1 = same ? win1_q[0] : line.upper;
			sel_d.g3 = same ? mag : win1_q[2];
		end else begin
			sel_d.major = ax;
			sel_d.minor = ay;
			sel_d.g2 = line.middle;
			sel_d.g4 = win1_q[1];
			sel_d.g1 = same ? mag : line.upper;
			sel_d.g3 = same ? win1_q[0] : win1_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win1_q[0] <= win2_q[0];
			win1_q[1] <= win2_q[1];
			win1_q[2] <= win2_q[2];
			win2_q[0] <= line.upper;
			win2_q[1] <= line.middle;
			win2_q[2] <= mag;
			held_gx_q <= line.gx;
			held_gy_q <= line.gy;
			sel_q <= sel_d;
		end
	end

	assign sel_s2 = sel_q;

endmodule

// ----- design/gnms_compare.sv -----
module gnms_compare (
	input  logic           clk,
	input  logic           en_s2,
	input  gnms_pkg::sel_t sel_s2,
	input  logic           en_s3,
	output logic           dec_s4
);
	import gnms_pkg::*;

	prods_t prods_s3;
	logic   dec_q;
	abs_t   diff;

	assign diff = sel_s2.major - sel_s2.minor;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prods_s3.force0 <= sel_s2.force0;
			prods_s3.pm <= prod_t'(sel_s2.m) * prod_t'(sel_s2.major);
			prods_s3.p1 <= prod_t'(sel_s2.minor) * prod_t'(sel_s2.g1);
			prods_s3.p2 <= prod_t'(diff) * prod_t'(sel_s2.g2);
			prods_s3.p3 <= prod_t'(sel_s2.minor) * prod_t'(sel_s2.g3);
			prods_s3.p4 <= prod_t'(diff) * prod_t'(sel_s2.g4);
		end
	end

	logic [PROD_BITS:0] pm_ext;
	logic [PROD_BITS:0] sum_a;
	logic [PROD_BITS:0] sum_b;

	assign pm_ext = {1'b0, prods_s3.pm};
	assign sum_a = {1'b0, prods_s3.p1} + {1'b0, prods_s3.p2};
	assign sum_b = {1'b0, prods_s3.p3} + {1'b0, prods_s3.p4};

	always_ff @(posedge clk) begin
		if (en_s3) begin
			dec_q <= !prods_s3.force0 && (pm_ext >= sum_a) && (pm_ext >= sum_b);
		end
	end

	assign dec_s4 = dec_q;

endmodule

// ----- design/gnms_emit.sv -----
module gnms_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  gnms_pkg::tag_t                tag,
	input  logic                          dec,
	output logic                          free,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gnms_pkg::ROW_BITS-1:0] out_row,
	output logic [gnms_pkg::COL_BITS-1:0] out_column,
	output logic                          is_local_max,
	output logic                          last_of_run
);
	import gnms_pkg::*;

	logic [RES_COUNT-1:0] mask_q;
	logic [RES_COUNT-1:0] rest;
	logic [RES_COUNT-1:0] low;
	tag_t                 tag_q;
	logic                 dec_q;

	assign rest = mask_q & (mask_q - RES_COUNT'(1));
	assign low = mask_q & ~rest;
	assign free = (mask_q == '0) || (out_ready && (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (free) begin
			mask_q <= item_valid ? tag.mask : '0;
		end else if (out_ready) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (free && item_valid) begin
			tag_q <= tag;
			dec_q <= dec;
		end
	end

	assign out_valid = (mask_q != '0);
	assign out_row = (low[RES_CENTER] || low[RES_ROW_END]) ? tag_q.row_m1 : tag_q.row;
	assign out_column = (low[RES_CENTER] || low[RES_LAST_ROW]) ? tag_q.col_m1 : tag_q.col;
	assign is_local_max = low[RES_CENTER] && dec_q;
	assign last_of_run = (rest == '0);

endmodule

// ----- design/gradient_nonmax_suppression_top.sv -----
// Channel  Direction  Handshake              Payload
// in       in         in_valid / in_ready    magnitude, grad_x, grad_y
// out      out        out_valid / out_ready  out_row, out_column, is_local_max, last_of_run
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat enters per clock while each beat gives at most one result and out_ready is high.
// A beat at the end of a row causes two results and one on the last row up to four;
// the serializer sends one result per clock while out_ready is high and stalls the input.
// The first result of a beat appears behind the line memory read and the window,
// multiplier, compare and serializer registers. Reset clears counters, valid bits and
// the result mask, loads the default frame size and clears no data register or line memory.
// A stalled output holds the pipeline once its last stage is occupied.
module gradient_nonmax_suppression_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gnms_pkg::mag_t                magnitude,
	input  gnms_pkg::grad_t               grad_x,
	input  gnms_pkg::grad_t               grad_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gnms_pkg::ROW_BITS-1:0] out_row,
	output logic [gnms_pkg::COL_BITS-1:0] out_column,
	output logic                          is_local_max,
	output logic                          last_of_run,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  gnms_pkg::cfg_reg_t            cfg_index,
	input  logic [gnms_pkg::CFG_BITS-1:0] cfg_data
);
	import gnms_pkg::*;

	logic [CFG_BITS-1:0] width_q;
	logic [CFG_BITS-1:0] height_q;
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;

	logic                s1_valid_q;
	logic                s2_valid_q;
	logic                s3_valid_q;
	logic                s4_valid_q;
	tag_t                tag_d;
	tag_t                tag_s1;
	tag_t                tag_s2;
	tag_t                tag_s3;
	tag_t                tag_s4;
	mag_t                mag_s1;
	grad_t               gx_s1;
	grad_t               gy_s1;

	logic                adv;
	logic                accept;
	logic                em_free;
	logic                ram_wr_en;
	logic                eor;
	logic                last_row;
	logic [CFG_BITS-1:0] w_eff;
	logic [CFG_BITS-1:0] h_eff;
	logic [CFG_BITS-1:0] col_ext;
	line_entry_t         line_rd;
	line_entry_t         line_wr;
	sel_t                sel_s2;
	logic                dec_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DEFAULT_WIDTH;
			height_q <= DEFAULT_HEIGHT;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: begin
					width_q <= cfg_data;
				end
				CFG_FRAME_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign adv = !s4_valid_q || em_free;
	assign in_ready = adv;
	assign accept = in_valid && adv;

	always_comb begin
		logic r_nz;
		logic c_nz;
		if (width_q < MIN_DIM) begin
			w_eff = MIN_DIM;
		end else if (width_q > CFG_BITS'(MAX_WIDTH)) begin
			w_eff = CFG_BITS'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q < MIN_DIM) ? MIN_DIM : height_q;
		col_ext = CFG_BITS'(col_q);
		eor = col_ext >= (w_eff - CFG_BITS'(1));
		last_row = row_q >= (h_eff - CFG_BITS'(1));
		r_nz = (row_q != '0);
		c_nz = (col_q != '0);
		tag_d.row = row_q;
		tag_d.row_m1 = row_q - ROW_BITS'(1);
		tag_d.col = col_q;
		tag_d.col_m1 = col_q - COL_BITS'(1);
		tag_d.mask[RES_CENTER] = r_nz && c_nz;
		tag_d.mask[RES_ROW_END] = r_nz && eor;
		tag_d.mask[RES_LAST_ROW] = r_nz && last_row && c_nz;
		tag_d.mask[RES_CORNER] = r_nz && last_row && eor;
		tag_d.border = (row_q == ROW_BITS'(1)) || (col_q == COL_BITS'(1)) ||
			(col_ext >= w_eff) || (row_q >= h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (eor) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
			s4_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= in_valid;
			s2_valid_q <= s1_valid_q;
			s3_valid_q <= s2_valid_q;
			s4_valid_q <= s3_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= tag_d;
			mag_s1 <= magnitude;
			gx_s1 <= grad_x;
			gy_s1 <= grad_y;
		end
		if (adv) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Consecutive beats always address different columns, so the write-back
	// of one beat never meets the read of the next at the same entry.
	assign ram_wr_en = adv && s1_valid_q;
	assign line_wr.upper = line_rd.middle;
	assign line_wr.middle = mag_s1;
	assign line_wr.gy = gy_s1;
	assign line_wr.gx = gx_s1;

	gnms_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (ADDR_BITS'(col_q)),
		.rd_data (line_rd),
		.wr_en   (ram_wr_en),
		.wr_addr (ADDR_BITS'(tag_s1.col)),
		.wr_data (line_wr)
	);

	gnms_window u_window (
		.clk    (clk),
		.en     (ram_wr_en),
		.line   (line_rd),
		.mag    (mag_s1),
		.border (tag_s1.border),
		.sel_s2 (sel_s2)
	);

	gnms_compare u_compare (
		.clk    (clk),
		.en_s2  (adv && s2_valid_q),
		.sel_s2 (sel_s2),
		.en_s3  (adv && s3_valid_q),
		.dec_s4 (dec_s4)
	);

	gnms_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (s4_valid_q),
		.tag          (tag_s4),
		.dec          (dec_s4),
		.free         (em_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_row      (out_row),
		.out_column   (out_column),
		.is_local_max (is_local_max),
		.last_of_run  (last_of_run)
	);

`include "gradient_nonmax_suppression_top_assert.svh"

	`GNMS_CHECK(a_line_no_collision, ram_wr_en && accept, tag_s1.col != col_q,
		"line memory read and write hit the same entry")
	`GNMS_CHECK(a_max_not_on_border, out_valid && is_local_max,
		(out_row != '0) && (out_column != '0), "local maximum reported on the frame border")
	`GNMS_CHECK_NEXT(a_emit_loads, s4_valid_q && em_free && (tag_s4.mask != '0), out_valid,
		"results of a beat were dropped at the serializer")

endmodule
